// ----- hw/rtl/sdspi_pkg.sv -----
package sdspi_pkg;

   localparam int SECTOR_BYTES_DEF = 512;

   localparam logic [4:0] PH_IDLE     = 5'd0;
   localparam logic [4:0] PH_WAKE     = 5'd1;
   localparam logic [4:0] PH_C_PRE    = 5'd2;
   localparam logic [4:0] PH_C_SEL    = 5'd3;
   localparam logic [4:0] PH_C_FRAME  = 5'd4;
   localparam logic [4:0] PH_C_POLL   = 5'd5;
   localparam logic [4:0] PH_R7       = 5'd6;
   localparam logic [4:0] PH_V2_GAP1  = 5'd7;
   localparam logic [4:0] PH_V2_GAP2  = 5'd8;
   localparam logic [4:0] PH_OCR      = 5'd9;
   localparam logic [4:0] PH_RW_FIRST = 5'd10;
   localparam logic [4:0] PH_RW_POLL  = 5'd11;
   localparam logic [4:0] PH_TOK      = 5'd12;
   localparam logic [4:0] PH_RD_DATA  = 5'd13;
   localparam logic [4:0] PH_RD_CRC   = 5'd14;
   localparam logic [4:0] PH_W_PRE    = 5'd15;
   localparam logic [4:0] PH_W_DATA   = 5'd16;
   localparam logic [4:0] PH_W_CRC    = 5'd17;
   localparam logic [4:0] PH_W_RESP   = 5'd18;
   localparam logic [4:0] PH_W_STOP   = 5'd19;
   localparam logic [4:0] PH_FIN      = 5'd20;

   localparam logic [3:0] K_CMD0    = 4'd0;
   localparam logic [3:0] K_CMD8    = 4'd1;
   localparam logic [3:0] K_V2_55   = 4'd2;
   localparam logic [3:0] K_V2_41   = 4'd3;
   localparam logic [3:0] K_58      = 4'd4;
   localparam logic [3:0] K_V1_55   = 4'd5;
   localparam logic [3:0] K_V1_41   = 4'd6;
   localparam logic [3:0] K_V1_LOOP = 4'd7;
   localparam logic [3:0] K_RD17    = 4'd8;
   localparam logic [3:0] K_RD_RDY  = 4'd9;
   localparam logic [3:0] K_WCMD    = 4'd10;
   localparam logic [3:0] K_W1_RDY  = 4'd11;
   localparam logic [3:0] K_WM_RDY  = 4'd12;
   localparam logic [3:0] K_WM_END  = 4'd13;
   localparam logic [3:0] K_SYNC    = 4'd14;

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_BYTE  = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;
   localparam logic [2:0] OP_SYNC  = 3'd5;

   localparam logic [2:0] REG_INIT_TO  = 3'd0;
   localparam logic [2:0] REG_READY_TO = 3'd1;
   localparam logic [2:0] REG_TOKEN_TO = 3'd2;
   localparam logic [2:0] REG_POLLS    = 3'd3;
   localparam logic [2:0] REG_WAKE     = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ERR   = 2'd1;
   localparam logic [1:0] ST_NRDY  = 2'd2;
   localparam logic [1:0] ST_PARAM = 2'd3;

   localparam logic [7:0] CMD0   = 8'h40;
   localparam logic [7:0] CMD1   = 8'h41;
   localparam logic [7:0] CMD8   = 8'h48;
   localparam logic [7:0] CMD17  = 8'h51;
   localparam logic [7:0] CMD24  = 8'h58;
   localparam logic [7:0] CMD25  = 8'h59;
   localparam logic [7:0] CMD58  = 8'h7A;
   localparam logic [7:0] CMD55  = 8'h77;
   localparam logic [7:0] ACMD41 = 8'hE9;
   localparam logic [7:0] CMD41A = 8'h69;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  drive_index;
      logic [31:0] sector_address;
      logic [15:0] block_count;
      logic [7:0]  miso_byte;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       want_write_byte;
      logic       done_res;
      logic [1:0] status;
      logic [1:0] card_kind;
      logic       not_initialized;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [15:0] data;
   } csr_type;

endpackage

// ----- hw/rtl/sdspi_if.sv -----
interface sdspi_req_if import sdspi_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdspi_rsp_if import sdspi_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdspi_csr_if import sdspi_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/sd_card_spi_host_engine_top.sv -----
// Each accepted request is answered from the response register in the
// cycle after. Throughput: one transaction per cycle unless rsp.ready
// holds it off; state is one pass of logic from engine to response regs.
// Reset (synchronous, active high): engine idle, card deselected, card type
// none, not initialized, registers at their default timeouts and counts.
module sd_card_spi_host_engine_top import sdspi_pkg::*; #(
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   sdspi_req_if.sink  req,
   sdspi_rsp_if.source rsp,
   sdspi_csr_if.sink  csr
);

   localparam int SB_SHIFT = $clog2(SECTOR_BYTES);
   localparam int BCW = SB_SHIFT + 1;
   localparam logic [BCW-1:0] SB_CNT = BCW'(SECTOR_BYTES);

   logic [15:0] init_to_ff, ready_to_ff, token_to_ff;
   logic [7:0]  polls_ff, wake_ff;

   logic [4:0]     phase_ff, phase_in;
   logic [BCW-1:0] bc_ff, bc_in;
   logic [7:0]     poll_ff, poll_in;
   logic [15:0]    ms_ff, ms_in;
   logic [1:0]     ctype_ff, ctype_in;
   logic           uninit_ff, uninit_in;
   logic [31:0]    arg_ff, arg_in;
   logic [15:0]    left_ff, left_in;
   logic [31:0]    ocr_ff, ocr_in;
   logic [7:0]     pcmd_ff, pcmd_in;
   logic [3:0]     afk_ff, afk_in;
   logic           app_ff, app_in;
   logic           cs_ff, cs_in;
   logic [1:0]     rc_ff, rc_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type o;

   logic    accept;
   req_type r;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign r = req.payload;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_to_ff <= 16'd3000;
         ready_to_ff <= 16'd2000;
         token_to_ff <= 16'd500;
         polls_ff <= 8'd255;
         wake_ff <= 8'd80;
      end else if (csr.valid) begin
         unique case (csr.payload.index)
            REG_INIT_TO:  init_to_ff <= csr.payload.data;
            REG_READY_TO: ready_to_ff <= csr.payload.data;
            REG_TOKEN_TO: token_to_ff <= csr.payload.data;
            REG_POLLS:    polls_ff <= csr.payload.data[7:0];
            REG_WAKE:     wake_ff <= csr.payload.data[7:0];
            default: ;
         endcase
      end
   end

   logic [7:0]  fc;
   logic [31:0] fa;
   logic [7:0]  frame;
   logic [31:0] ocr_sh;
   logic [BCW-1:0] bc_p1;
   logic [7:0]  rv;
   logic        do_resume;
   logic [31:0] scaled;

   always_comb begin
      fc = app_ff ? CMD55 : {1'b0, pcmd_ff[6:0]};
      fa = app_ff ? 32'd0 : arg_ff;
      bc_p1 = bc_ff + 1'b1;
      unique case (bc_p1[2:0])
         3'd1: frame = fa[31:24];
         3'd2: frame = fa[23:16];
         3'd3: frame = fa[15:8];
         3'd4: frame = fa[7:0];
         default: frame = (fc == CMD0) ? 8'h95 : ((fc == CMD8) ? 8'h87 : 8'h01);
      endcase
      ocr_sh = {ocr_ff[23:0], r.miso_byte};
      scaled = (ctype_ff != 2'd3) ? (r.sector_address << SB_SHIFT) : r.sector_address;
   end

   always_comb begin
      phase_in = phase_ff; bc_in = bc_ff; poll_in = poll_ff; ms_in = ms_ff;
      ctype_in = ctype_ff; uninit_in = uninit_ff; arg_in = arg_ff; left_in = left_ff;
      ocr_in = ocr_ff; pcmd_in = pcmd_ff; afk_in = afk_ff; app_in = app_ff;
      cs_in = cs_ff; rc_in = rc_ff;
      o = '0;
      do_resume = 1'b0;
      rv = r.miso_byte;

      if (r.opcode == OP_BYTE) begin
         unique case (phase_ff)
            PH_IDLE: ;
            PH_WAKE: begin
               bc_in = bc_ff - 1'b1;
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b0;
               if (bc_in == '0) begin
                  pcmd_in = CMD0; arg_in = '0; afk_in = K_CMD0; app_in = 1'b0;
                  phase_in = PH_C_PRE;
               end
            end
            PH_C_PRE: begin
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b1; phase_in = PH_C_SEL;
            end
            PH_C_SEL: begin
               bc_in = '0; o.tx_valid = 1'b1; o.tx_byte = fc; cs_in = 1'b1;
               phase_in = PH_C_FRAME;
            end
            PH_C_FRAME: begin
               bc_in = bc_p1; o.tx_valid = 1'b1; cs_in = 1'b1;
               if (bc_p1 <= BCW'(5)) o.tx_byte = frame;
               else begin
                  poll_in = polls_ff; o.tx_byte = 8'hFF; phase_in = PH_C_POLL;
               end
            end
            PH_C_POLL: begin
               poll_in = poll_ff - 1'b1;
               if (r.miso_byte[7] && poll_in != 8'd0) begin
                  o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b1;
               end else if (app_ff && r.miso_byte <= 8'd1) begin
                  app_in = 1'b0; o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b0;
                  phase_in = PH_C_PRE;
               end else do_resume = 1'b1;
            end
            PH_R7, PH_OCR: begin
               ocr_in = ocr_sh; bc_in = bc_p1;
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
               if (bc_p1 < BCW'(4)) cs_in = 1'b1;
               else if (phase_ff == PH_OCR) begin
                  ctype_in = ocr_sh[30] ? 2'd3 : 2'd2; uninit_in = 1'b0;
                  rc_in = ST_OK; cs_in = 1'b0; phase_in = PH_FIN;
               end else if (ocr_sh[15:0] == 16'h01AA) begin
                  ms_in = '0; cs_in = 1'b0;
                  if (init_to_ff == 16'd0) begin
                     ctype_in = 2'd0; uninit_in = 1'b1; rc_in = ST_ERR; phase_in = PH_FIN;
                  end else begin
                     pcmd_in = CMD55; arg_in = '0; afk_in = K_V2_55; app_in = 1'b0;
                     phase_in = PH_C_PRE;
                  end
               end else begin
                  ctype_in = 2'd0; uninit_in = 1'b1; rc_in = ST_ERR; cs_in = 1'b0;
                  phase_in = PH_FIN;
               end
            end
            PH_V2_GAP1: begin
               pcmd_in = CMD41A; arg_in = 32'h4000_0000; afk_in = K_V2_41; app_in = 1'b0;
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b0; phase_in = PH_C_PRE;
            end
            PH_V2_GAP2: begin
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b0;
               if (bc_ff == '0) begin
                  pcmd_in = CMD58; arg_in = '0; afk_in = K_58; app_in = 1'b0;
                  phase_in = PH_C_PRE;
               end else if (ms_ff >= init_to_ff) begin
                  ctype_in = 2'd0; uninit_in = 1'b1; rc_in = ST_ERR; phase_in = PH_FIN;
               end else begin
                  pcmd_in = CMD55; arg_in = '0; afk_in = K_V2_55; app_in = 1'b0;
                  phase_in = PH_C_PRE;
               end
            end
            PH_RW_FIRST: begin
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF; phase_in = PH_RW_POLL;
            end
            PH_RW_POLL: begin
               if (r.miso_byte == 8'hFF) begin do_resume = 1'b1; rv = 8'd1; end
               else if (ms_ff >= ready_to_ff) begin do_resume = 1'b1; rv = 8'd0; end
               else begin o.tx_valid = 1'b1; o.tx_byte = 8'hFF; end
            end
            PH_TOK: begin
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
               if (ms_ff < token_to_ff) begin
                  cs_in = 1'b1;
                  if (r.miso_byte == 8'hFE) begin bc_in = '0; phase_in = PH_RD_DATA; end
               end else begin rc_in = ST_ERR; cs_in = 1'b0; phase_in = PH_FIN; end
            end
            PH_RD_DATA: begin
               o.read_valid = 1'b1; o.read_byte = r.miso_byte;
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b1;
               bc_in = bc_p1;
               if (bc_p1 >= SB_CNT) begin bc_in = '0; phase_in = PH_RD_CRC; end
            end
            PH_RD_CRC: begin
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
               if (bc_ff == '0) begin bc_in = BCW'(1); cs_in = 1'b1; end
               else begin rc_in = ST_OK; cs_in = 1'b0; phase_in = PH_FIN; end
            end
            PH_W_PRE: begin
               o.tx_valid = 1'b1; o.tx_byte = (pcmd_ff == CMD25) ? 8'hFC : 8'hFE;
               o.want_write_byte = 1'b1; cs_in = 1'b1; bc_in = '0; phase_in = PH_W_DATA;
            end
            PH_W_DATA: begin
               o.tx_valid = 1'b1; cs_in = 1'b1;
               if (bc_ff < SB_CNT) begin
                  bc_in = bc_p1; o.tx_byte = r.write_byte;
                  o.want_write_byte = bc_p1 < SB_CNT;
               end else begin bc_in = '0; o.tx_byte = 8'hFF; phase_in = PH_W_CRC; end
            end
            PH_W_CRC: begin
               if (bc_ff == '0) bc_in = BCW'(1); else phase_in = PH_W_RESP;
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b1;
            end
            PH_W_RESP: begin
               o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
               if (r.miso_byte[4:0] == 5'h05) begin
                  afk_in = (pcmd_ff != CMD25) ? K_W1_RDY : K_WM_RDY;
                  ms_in = '0; phase_in = PH_RW_FIRST;
               end else if (pcmd_ff != CMD25) begin
                  rc_in = ST_ERR; cs_in = 1'b0; phase_in = PH_FIN;
               end else begin
                  o.tx_byte = 8'hFD; cs_in = 1'b1; phase_in = PH_W_STOP;
               end
            end
            PH_W_STOP: begin
               afk_in = K_WM_END; ms_in = '0; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
               phase_in = PH_RW_FIRST;
            end
            default: begin
               phase_in = PH_IDLE; o.done_res = 1'b1; o.status = rc_ff;
            end
         endcase

         if (do_resume) begin
            o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
            unique case (afk_ff)
               K_CMD0: begin
                  cs_in = 1'b0;
                  if (rv == 8'd1) begin
                     pcmd_in = CMD8; arg_in = 32'h1AA; afk_in = K_CMD8; app_in = 1'b0;
                     phase_in = PH_C_PRE;
                  end else begin
                     ctype_in = 2'd0; uninit_in = 1'b1; rc_in = ST_ERR; phase_in = PH_FIN;
                  end
               end
               K_CMD8: begin
                  if (rv == 8'd1) begin
                     ocr_in = '0; bc_in = '0; cs_in = 1'b1; phase_in = PH_R7;
                  end else begin
                     ms_in = '0; cs_in = 1'b0;
                     pcmd_in = CMD55; arg_in = '0; afk_in = K_V1_55; app_in = 1'b0;
                     phase_in = PH_C_PRE;
                  end
               end
               K_V2_55: phase_in = PH_V2_GAP1;
               K_V2_41: begin bc_in = BCW'(rv); phase_in = PH_V2_GAP2; end
               K_58: begin
                  if (rv == 8'd0) begin
                     ocr_in = '0; bc_in = '0; cs_in = 1'b1; phase_in = PH_OCR;
                  end else begin
                     ctype_in = 2'd0; uninit_in = 1'b1; rc_in = ST_ERR; cs_in = 1'b0;
                     phase_in = PH_FIN;
                  end
               end
               K_V1_55, K_V1_41, K_V1_LOOP: begin
                  cs_in = 1'b0;
                  if (afk_ff == K_V1_55 && rv <= 8'd1) begin
                     pcmd_in = CMD41A; arg_in = '0; afk_in = K_V1_41; app_in = 1'b0;
                     phase_in = PH_C_PRE;
                  end else if (afk_ff == K_V1_LOOP && rv == 8'd0) begin
                     ctype_in = (ms_ff < init_to_ff) ? 2'd1 : 2'd0;
                     uninit_in = !(ms_ff < init_to_ff);
                     rc_in = (ms_ff < init_to_ff) ? ST_OK : ST_ERR;
                     phase_in = PH_FIN;
                  end else if (ms_ff >= init_to_ff) begin
                     ctype_in = 2'd0; uninit_in = 1'b1; rc_in = ST_ERR; phase_in = PH_FIN;
                  end else begin
                     priority if (afk_ff == K_V1_55) pcmd_in = CMD1;
                     else if (afk_ff == K_V1_41) pcmd_in = (rv <= 8'd1) ? ACMD41 : CMD1;
                     else pcmd_in = pcmd_ff;
                     arg_in = '0; afk_in = K_V1_LOOP; app_in = pcmd_in[7];
                     phase_in = PH_C_PRE;
                  end
               end
               K_RD17: begin
                  if (rv == 8'd0) begin
                     afk_in = K_RD_RDY; ms_in = '0; phase_in = PH_RW_FIRST;
                  end else begin rc_in = ST_ERR; cs_in = 1'b0; phase_in = PH_FIN; end
               end
               K_RD_RDY: begin
                  if (rv != 8'd0) begin ms_in = '0; cs_in = 1'b1; phase_in = PH_TOK; end
                  else begin rc_in = ST_ERR; cs_in = 1'b0; phase_in = PH_FIN; end
               end
               K_WCMD: begin
                  if (rv == 8'd0) begin cs_in = 1'b1; phase_in = PH_W_PRE; end
                  else begin rc_in = ST_ERR; cs_in = 1'b0; phase_in = PH_FIN; end
               end
               K_W1_RDY: begin rc_in = ST_OK; cs_in = 1'b0; phase_in = PH_FIN; end
               K_WM_RDY: begin
                  left_in = left_ff - 1'b1; cs_in = 1'b1;
                  if (left_in != 16'd0) begin
                     o.tx_byte = 8'hFC; o.want_write_byte = 1'b1; bc_in = '0;
                     phase_in = PH_W_DATA;
                  end else begin o.tx_byte = 8'hFD; phase_in = PH_W_STOP; end
               end
               K_WM_END: begin
                  rc_in = (left_ff != 16'd0) ? ST_ERR : ST_OK; cs_in = 1'b0;
                  phase_in = PH_FIN;
               end
               default: begin
                  rc_in = (rv != 8'd0) ? ST_OK : ST_ERR; cs_in = 1'b0; phase_in = PH_FIN;
               end
            endcase
         end
      end else if (r.opcode == OP_TICK) begin
         if (ms_ff != 16'hFFFF) ms_in = ms_ff + 1'b1;
      end else if (phase_ff == PH_IDLE && r.opcode <= OP_SYNC) begin
         if (r.drive_index != 8'd0 ||
             ((r.opcode == OP_READ || r.opcode == OP_WRITE) && r.block_count == 16'd0)) begin
            o.done_res = 1'b1; o.status = ST_PARAM;
         end else if (r.opcode == OP_INIT) begin
            bc_in = (wake_ff != 8'd0) ? BCW'(wake_ff) : BCW'(256);
            o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b0; phase_in = PH_WAKE;
         end else if (uninit_ff) begin
            o.done_res = 1'b1; o.status = ST_NRDY;
         end else if (r.opcode == OP_SYNC) begin
            afk_in = K_SYNC; ms_in = '0; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
            phase_in = PH_RW_FIRST;
         end else begin
            o.tx_valid = 1'b1; o.tx_byte = 8'hFF; cs_in = 1'b0;
            if (r.opcode == OP_READ && r.block_count != 16'd1) begin
               rc_in = ST_ERR; phase_in = PH_FIN;
            end else begin
               if (r.opcode == OP_WRITE) left_in = r.block_count;
               priority if (r.opcode == OP_READ) begin
                  pcmd_in = CMD17; afk_in = K_RD17;
               end else begin
                  pcmd_in = (r.block_count == 16'd1) ? CMD24 : CMD25; afk_in = K_WCMD;
               end
               arg_in = scaled; app_in = 1'b0; phase_in = PH_C_PRE;
            end
         end
      end

      o.chip_select = cs_in;
      o.card_kind = ctype_in;
      o.not_initialized = uninit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; bc_ff <= '0; poll_ff <= '0; ms_ff <= '0;
         ctype_ff <= '0; uninit_ff <= 1'b1; arg_ff <= '0; left_ff <= '0;
         ocr_ff <= '0; pcmd_ff <= '0; afk_ff <= K_CMD0; app_ff <= 1'b0;
         cs_ff <= 1'b0; rc_ff <= ST_OK; rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in; bc_ff <= bc_in; poll_ff <= poll_in; ms_ff <= ms_in;
            ctype_ff <= ctype_in; uninit_ff <= uninit_in; arg_ff <= arg_in;
            left_ff <= left_in; ocr_ff <= ocr_in; pcmd_ff <= pcmd_in;
            afk_ff <= afk_in; app_ff <= app_in; cs_ff <= cs_in; rc_ff <= rc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= o;
   end

endmodule
